### rtl/core/etfp_pkg.sv
// Shared types, constants and helpers for the escape-time fractal pixel unit.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package etfp_pkg;

  // Fixed-point formats: Q4.28 coordinates, Q8.56 products
  localparam int unsigned Q_W     = 32;
  localparam int unsigned STEP_W  = 31;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned FRAC_W  = 28;
  localparam int unsigned SAT_W   = 50;

  // Pixel index width is fixed by the input beat layout
  localparam int unsigned PIXEL_INDEX_BITS = 10;
  localparam int unsigned ITER_W           = 11;
  localparam int unsigned COLOR_W          = 8;
  localparam int unsigned MAX_ITERATIONS   = 1024;

  // Red channel wraps at this count
  localparam logic [COLOR_W-1:0] RED_LAST = 8'd254;

  // |z|^2 escape bound, 4.0 in Q8.56
  localparam logic [PROD_W-1:0] ESCAPE_Q56 = 64'h0400_0000_0000_0000;

  // Configuration register reset values
  localparam logic              RST_MODE     = 1'b0;
  localparam logic [Q_W-1:0]    RST_X_MIN    = 32'hE000_0000;
  localparam logic [Q_W-1:0]    RST_Y_MIN    = 32'hEC00_0000;
  localparam logic [STEP_W-1:0] RST_X_STEP   = 31'd958698;
  localparam logic [STEP_W-1:0] RST_Y_STEP   = 31'd958698;
  localparam logic [Q_W-1:0]    RST_JULIA_RE = 32'hF400_0000;
  localparam logic [Q_W-1:0]    RST_JULIA_IM = 32'h00F5_C28F;
  localparam logic [ITER_W-1:0] RST_LIMIT    = 11'd1024;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MODE     = 3'd0,
    CFG_X_MIN    = 3'd1,
    CFG_Y_MIN    = 3'd2,
    CFG_X_STEP   = 3'd3,
    CFG_Y_STEP   = 3'd4,
    CFG_JULIA_RE = 3'd5,
    CFG_JULIA_IM = 3'd6,
    CFG_LIMIT    = 3'd7
  } cfg_idx_e;

  // Fractal mode codes
  localparam logic MODE_MANDELBROT = 1'b0;
  localparam logic MODE_JULIA      = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic signed [Q_W-1:0]    x_min;
    logic signed [Q_W-1:0]    y_min;
    logic [STEP_W-1:0]        x_step;
    logic [STEP_W-1:0]        y_step;
    logic signed [Q_W-1:0]    julia_re;
    logic signed [Q_W-1:0]    julia_im;
    logic [ITER_W-1:0]        limit;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_INDEX_BITS-1:0] column;
    logic [PIXEL_INDEX_BITS-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic               escaped;
    logic [ITER_W-1:0]  iterations;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } result_t;

  // Clamp a wide signed value to the signed Q4.28 range
  function automatic logic signed [Q_W-1:0] sat_q28(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'($signed({1'b0, {(Q_W-1){1'b1}}}));
    lo = SAT_W'($signed({1'b1, {(Q_W-1){1'b0}}}));
    if (v > hi) begin
      sat_q28 = {1'b0, {(Q_W-1){1'b1}}};
    end else if (v < lo) begin
      sat_q28 = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      sat_q28 = v[Q_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/etfp_cfg_regs.sv
// Configuration register file for the escape-time fractal pixel unit.
// Depends on etfp_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module etfp_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  input  wire logic [2:0]                 cfg_addr_i,
  input  wire logic [etfp_pkg::Q_W-1:0]   cfg_data_i,
  output etfp_pkg::cfg_t                  cfg_o
);

  etfp_pkg::cfg_t cfg_q;
  etfp_pkg::cfg_t cfg_d;

  // Decode one write beat into the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (etfp_pkg::cfg_idx_e'(cfg_addr_i))
        etfp_pkg::CFG_MODE:     cfg_d.mode     = cfg_data_i[0];
        etfp_pkg::CFG_X_MIN:    cfg_d.x_min    = cfg_data_i;
        etfp_pkg::CFG_Y_MIN:    cfg_d.y_min    = cfg_data_i;
        etfp_pkg::CFG_X_STEP:   cfg_d.x_step   = cfg_data_i[etfp_pkg::STEP_W-1:0];
        etfp_pkg::CFG_Y_STEP:   cfg_d.y_step   = cfg_data_i[etfp_pkg::STEP_W-1:0];
        etfp_pkg::CFG_JULIA_RE: cfg_d.julia_re = cfg_data_i;
        etfp_pkg::CFG_JULIA_IM: cfg_d.julia_im = cfg_data_i;
        etfp_pkg::CFG_LIMIT:    cfg_d.limit    = cfg_data_i[etfp_pkg::ITER_W-1:0];
        default:                cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode     <= etfp_pkg::RST_MODE;
      cfg_q.x_min    <= etfp_pkg::RST_X_MIN;
      cfg_q.y_min    <= etfp_pkg::RST_Y_MIN;
      cfg_q.x_step   <= etfp_pkg::RST_X_STEP;
      cfg_q.y_step   <= etfp_pkg::RST_Y_STEP;
      cfg_q.julia_re <= etfp_pkg::RST_JULIA_RE;
      cfg_q.julia_im <= etfp_pkg::RST_JULIA_IM;
      cfg_q.limit    <= etfp_pkg::RST_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/core/etfp_mult.sv
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on etfp_pkg for the operand and product widths.
`default_nettype none

module etfp_mult (
  input  wire logic                              clk_i,
  input  wire logic signed [etfp_pkg::Q_W-1:0]   a_i,
  input  wire logic signed [etfp_pkg::Q_W-1:0]   b_i,
  output logic signed [etfp_pkg::PROD_W-1:0]     prod_o
);

  logic signed [etfp_pkg::PROD_W-1:0] prod_q;

  // Register every product; the sequencer reads it in the cycle after it sets the operands
  always_ff @(posedge clk_i) begin
    prod_q <= etfp_pkg::PROD_W'(a_i) * etfp_pkg::PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

### rtl/core/etfp_seq.sv
// Sequencer and datapath: maps the pixel, runs z = z^2 + c on the shared
// multiplier and forms the result beat. Depends on etfp_pkg.
`default_nettype none

module etfp_seq #(
  parameter int unsigned MAX_ITERATIONS = etfp_pkg::MAX_ITERATIONS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire etfp_pkg::pixel_t                  pixel_i,
  input  wire etfp_pkg::cfg_t                    cfg_i,
  input  wire logic signed [etfp_pkg::PROD_W-1:0] prod_i,
  output logic signed [etfp_pkg::Q_W-1:0]        mul_a_o,
  output logic signed [etfp_pkg::Q_W-1:0]        mul_b_o,
  output logic                                   busy_o,
  output logic                                   res_valid_o,
  output etfp_pkg::result_t                      res_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ITERATIONS + 1);
  localparam int unsigned LIM_W = (CNT_W > etfp_pkg::ITER_W) ? CNT_W : etfp_pkg::ITER_W;
  localparam int unsigned Q_W   = etfp_pkg::Q_W;
  localparam int unsigned P_W   = etfp_pkg::PROD_W;
  localparam int unsigned S_W   = etfp_pkg::SAT_W;
  localparam int unsigned PX_W  = etfp_pkg::PIXEL_INDEX_BITS;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MAPX = 8'b0000_0010,
    S_MAPY = 8'b0000_0100,
    S_LOAD = 8'b0000_1000,
    S_SQA  = 8'b0001_0000,
    S_SQB  = 8'b0010_0000,
    S_CHK  = 8'b0100_0000,
    S_UPD  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [PX_W-1:0]                col_q, col_d;
  logic [PX_W-1:0]                row_q, row_d;
  logic [CNT_W-1:0]               lim_q, lim_d;
  logic [CNT_W-1:0]               n_q, n_d;
  logic [etfp_pkg::COLOR_W-1:0]   red_q, red_d;
  logic                           first_q, first_d;
  logic signed [Q_W-1:0]          za_q, za_d;
  logic signed [Q_W-1:0]          zb_q, zb_d;
  logic signed [Q_W-1:0]          ca_q, ca_d;
  logic signed [Q_W-1:0]          cb_q, cb_d;
  logic signed [P_W-1:0]          sa_q, sa_d;
  logic signed [P_W-1:0]          diff_q, diff_d;
  logic                           res_valid_q, res_valid_d;
  etfp_pkg::result_t              res_q, res_d;

  logic [LIM_W-1:0]               lim_ext;
  logic [CNT_W-1:0]               n_inc;
  logic [P_W-1:0]                 mag;
  logic                           esc_now;
  logic signed [S_W-1:0]          map_x_sum;
  logic signed [S_W-1:0]          map_y_sum;
  logic signed [S_W-1:0]          re_sum;
  logic signed [S_W-1:0]          im_sum;
  logic signed [P_W-1:0]          diff_shift;
  logic signed [P_W-1:0]          prod_shift;

  // Clamp the configured limit into 1 .. MAX_ITERATIONS
  always_comb begin
    lim_ext = LIM_W'(cfg_i.limit);
    if (lim_ext == '0) begin
      lim_d = CNT_W'(1);
    end else if (lim_ext > LIM_W'(MAX_ITERATIONS)) begin
      lim_d = CNT_W'(MAX_ITERATIONS);
    end else begin
      lim_d = CNT_W'(lim_ext);
    end
  end

  // Datapath terms shared by several states
  assign n_inc      = n_q + CNT_W'(1);
  assign mag        = $unsigned(sa_q) + $unsigned(prod_i);
  assign esc_now    = (mag > etfp_pkg::ESCAPE_Q56);
  assign map_x_sum  = S_W'(cfg_i.x_min) + S_W'(prod_i);
  assign map_y_sum  = S_W'(cfg_i.y_min) + S_W'(prod_i);
  assign diff_shift = diff_q >>> etfp_pkg::FRAC_W;
  assign prod_shift = prod_i >>> (etfp_pkg::FRAC_W - 1);
  assign re_sum     = S_W'(diff_shift) + S_W'(ca_q);
  assign im_sum     = S_W'(prod_shift) + S_W'(cb_q);

  // Pick multiplier operands for the current step
  always_comb begin
    mul_a_o = '0;
    mul_b_o = '0;
    unique case (state_q)
      S_MAPX: begin
        mul_a_o = Q_W'(col_q);
        mul_b_o = Q_W'(cfg_i.x_step);
      end
      S_MAPY: begin
        mul_a_o = Q_W'(row_q);
        mul_b_o = Q_W'(cfg_i.y_step);
      end
      S_SQA: begin
        mul_a_o = za_q;
        mul_b_o = za_q;
      end
      S_SQB: begin
        mul_a_o = zb_q;
        mul_b_o = zb_q;
      end
      S_CHK: begin
        mul_a_o = za_q;
        mul_b_o = zb_q;
      end
      default: begin
        mul_a_o = '0;
        mul_b_o = '0;
      end
    endcase
  end

  // Advance the sequencer
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    n_d         = n_q;
    red_d       = red_q;
    first_d     = first_q;
    za_d        = za_q;
    zb_d        = zb_q;
    ca_d        = ca_q;
    cb_d        = cb_q;
    sa_d        = sa_q;
    diff_d      = diff_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          col_d   = pixel_i.column;
          row_d   = pixel_i.row;
          state_d = S_MAPX;
        end
      end
      S_MAPX: state_d = S_MAPY;
      S_MAPY: begin
        za_d    = etfp_pkg::sat_q28(map_x_sum);
        state_d = S_LOAD;
      end
      S_LOAD: begin
        zb_d = etfp_pkg::sat_q28(map_y_sum);
        if (cfg_i.mode == etfp_pkg::MODE_JULIA) begin
          ca_d = cfg_i.julia_re;
          cb_d = cfg_i.julia_im;
        end else begin
          ca_d = za_q;
          cb_d = etfp_pkg::sat_q28(map_y_sum);
        end
        n_d     = CNT_W'(1);
        red_d   = etfp_pkg::COLOR_W'(1);
        first_d = 1'b1;
        state_d = S_SQA;
      end
      S_SQA: state_d = S_SQB;
      S_SQB: begin
        sa_d    = prod_i;
        state_d = S_CHK;
      end
      S_CHK: begin
        diff_d  = sa_q - prod_i;
        state_d = S_UPD;
        // Finish on the start point alone, on escape, or on reaching the limit
        if (first_q && (lim_q == CNT_W'(1))) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (!first_q && esc_now) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (!first_q && (n_inc == lim_q)) begin
          n_d         = n_inc;
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (!first_q) begin
          n_d   = n_inc;
          red_d = (red_q == etfp_pkg::RED_LAST) ? '0 : red_q + etfp_pkg::COLOR_W'(1);
        end
        res_d.escaped    = esc_now;
        res_d.iterations = etfp_pkg::ITER_W'(n_d);
        res_d.red        = esc_now ? red_q : '0;
        res_d.green      = esc_now ? n_q[etfp_pkg::COLOR_W-1:0] : '0;
        res_d.blue       = esc_now ? mag[P_W-1 -: etfp_pkg::COLOR_W] : '0;
      end
      S_UPD: begin
        za_d    = etfp_pkg::sat_q28(re_sum);
        zb_d    = etfp_pkg::sat_q28(im_sum);
        first_d = 1'b0;
        state_d = S_SQA;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      first_q     <= first_d;
    end
  end

  // Hold payload and working registers
  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    row_q  <= row_d;
    n_q    <= n_d;
    red_q  <= red_d;
    za_q   <= za_d;
    zb_q   <= zb_d;
    ca_q   <= ca_d;
    cb_q   <= cb_d;
    sa_q   <= sa_d;
    diff_q <= diff_d;
    res_q  <= res_d;
    if (state_q == S_IDLE) begin
      lim_q <= lim_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### rtl/core/escape_time_fractal_pixel_unit.sv
// Top level of the escape-time fractal pixel unit (Mandelbrot / Julia).
// Depends on etfp_pkg, etfp_cfg_regs, etfp_mult and etfp_seq.
`default_nettype none

// A pixel beat is taken when start_i is high and busy_o is low; busy_o then
// stays high until the pixel is done, and its result appears on res_o for
// exactly one cycle with res_valid_o high, in the first cycle with busy_o low
// again. The receiver cannot stall, so capture the result on that strobe. A
// pixel runs k z^2 + c steps, where k is the count for an escaped pixel, the
// limit minus one for a pixel that does not escape, and zero for a limit of
// one. The unit has a single shared 32x32 multiplier, which computes the two
// coordinate products, then a*a, b*b and a*b once per step. The next pixel
// may start in the cycle in which the previous result is shown. Write the
// configuration registers only while busy_o is low; cfg_ready_o is always
// high.
module escape_time_fractal_pixel_unit #(
  parameter int unsigned MAX_ITERATIONS = etfp_pkg::MAX_ITERATIONS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire etfp_pkg::pixel_t          pixel_i,
  output logic                           busy_o,
  output logic                           res_valid_o,
  output etfp_pkg::result_t              res_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [2:0]                cfg_addr_i,
  input  wire logic [etfp_pkg::Q_W-1:0]  cfg_data_i
);

  etfp_pkg::cfg_t                      cfg;
  logic signed [etfp_pkg::Q_W-1:0]     mul_a;
  logic signed [etfp_pkg::Q_W-1:0]     mul_b;
  logic signed [etfp_pkg::PROD_W-1:0]  prod;

  assign cfg_ready_o = 1'b1;

  etfp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  etfp_mult u_mult (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  etfp_seq #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .pixel_i     (pixel_i),
    .cfg_i       (cfg),
    .prod_i      (prod),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // A result strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held longer than one cycle");

  // Every drop of busy comes with a result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> res_valid_o)
    else $error("busy dropped without a result beat");

  // An accepted pixel makes the unit busy at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("pixel accepted but unit not busy");

  // A pixel that did not escape is black
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.escaped) |->
      (res_o.red == '0 && res_o.green == '0 && res_o.blue == '0))
    else $error("non-escaped pixel has a color");

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for escape_time_fractal_pixel_unit (Mandelbrot / Julia).
// Predicts every pixel result in fixed point and checks each result strobe in order.
// Depends on etfp_pkg and the RTL under rtl/core only.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import etfp_pkg::*;

  localparam longint Q28_MAX       = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q28_MIN       = 64'shFFFF_FFFF_8000_0000;
  localparam int     RANDOM_PIXELS = 1120;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              start_i     = 1'b0;
  pixel_t            pixel_i     = '0;
  logic              busy_o;
  logic              res_valid_o;
  result_t           res_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [2:0]        cfg_addr_i  = '0;
  logic [Q_W-1:0]    cfg_data_i  = '0;

  // Pixels waiting to be sent, results waiting to be seen
  pixel_t            pending_pixels[$];
  result_t           predicted_results[$];
  cfg_t              cfg_copy;
  int                pixels_queued = 0;
  int                pixels_taken  = 0;
  int                mismatches    = 0;
  int                burst_left    = 1;
  int                gap_left      = 0;

  escape_time_fractal_pixel_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .pixel_i     (pixel_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Guard against a hung handshake
  initial begin
    #40_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic cfg_t reset_setting();
    cfg_t c;
    c.mode     = RST_MODE;
    c.x_min    = RST_X_MIN;
    c.y_min    = RST_Y_MIN;
    c.x_step   = RST_X_STEP;
    c.y_step   = RST_Y_STEP;
    c.julia_re = RST_JULIA_RE;
    c.julia_im = RST_JULIA_IM;
    c.limit    = RST_LIMIT;
    return c;
  endfunction

  function automatic longint clamp_q28(longint v);
    if (v > Q28_MAX) return Q28_MAX;
    if (v < Q28_MIN) return Q28_MIN;
    return v;
  endfunction

  // |z|^2 as an unsigned Q8.56 value
  function automatic logic [63:0] mag_q56(longint a, longint b);
    logic [63:0] aa;
    logic [63:0] bb;
    aa = a * a;
    bb = b * b;
    return aa + bb;
  endfunction

  // Map the pixel to a point and iterate z = z^2 + c until escape or limit
  function automatic result_t escape_pixel(pixel_t px);
    longint      pre;
    longint      pim;
    longint      za;
    longint      zb;
    longint      ca;
    longint      cb;
    longint      nre;
    longint      nim;
    logic [63:0] mag;
    int unsigned lim;
    int unsigned n;
    result_t     r;
    pre = clamp_q28(longint'($signed(cfg_copy.x_min))
                    + longint'(px.column) * longint'(cfg_copy.x_step));
    pim = clamp_q28(longint'($signed(cfg_copy.y_min))
                    + longint'(px.row) * longint'(cfg_copy.y_step));
    za = pre;
    zb = pim;
    if (cfg_copy.mode == MODE_JULIA) begin
      ca = longint'($signed(cfg_copy.julia_re));
      cb = longint'($signed(cfg_copy.julia_im));
    end else begin
      ca = pre;
      cb = pim;
    end
    lim = int'(cfg_copy.limit);
    if (lim == 0) lim = 1;
    if (lim > MAX_ITERATIONS) lim = MAX_ITERATIONS;
    n = 1;
    mag = mag_q56(za, zb);
    while (n < lim) begin
      nre = clamp_q28(((za * za - zb * zb) >>> FRAC_W) + ca);
      nim = clamp_q28(((za * zb) >>> (FRAC_W - 1)) + cb);
      za = nre;
      zb = nim;
      mag = mag_q56(za, zb);
      if (mag > ESCAPE_Q56) break;
      n++;
    end
    r.escaped    = mag > ESCAPE_Q56;
    r.iterations = ITER_W'(n);
    r.red        = r.escaped ? COLOR_W'(n % 255) : '0;
    r.green      = r.escaped ? COLOR_W'(n) : '0;
    r.blue       = r.escaped ? mag[63:56] : '0;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < 100) $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic queue_pixel(int column, int row);
    pixel_t p;
    p.column = PIXEL_INDEX_BITS'(column);
    p.row    = PIXEL_INDEX_BITS'(row);
    pending_pixels.push_back(p);
    pixels_queued++;
  endtask

  // Wait until every queued pixel is taken and every result is back
  task automatic drain_pixels();
    do @(negedge clk_i);
    while (pixels_taken != pixels_queued || predicted_results.size() != 0);
  endtask

  // Call at a rising edge; returns at the edge that takes the write
  task automatic write_register(cfg_idx_e idx, logic [Q_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      CFG_MODE:     cfg_copy.mode     = data[0];
      CFG_X_MIN:    cfg_copy.x_min    = data;
      CFG_Y_MIN:    cfg_copy.y_min    = data;
      CFG_X_STEP:   cfg_copy.x_step   = data[STEP_W-1:0];
      CFG_Y_STEP:   cfg_copy.y_step   = data[STEP_W-1:0];
      CFG_JULIA_RE: cfg_copy.julia_re = data;
      CFG_JULIA_IM: cfg_copy.julia_im = data;
      CFG_LIMIT:    cfg_copy.limit    = data[ITER_W-1:0];
      default: ;
    endcase
  endtask

  // Write every register; unused upper data bits carry noise
  task automatic program_all(cfg_t c);
    logic [Q_W-1:0] noise;
    noise = $urandom;
    @(posedge clk_i);
    write_register(CFG_MODE,     {noise[Q_W-1:1], c.mode});
    write_register(CFG_X_MIN,    c.x_min);
    write_register(CFG_Y_MIN,    c.y_min);
    write_register(CFG_X_STEP,   {noise[Q_W-1], c.x_step});
    write_register(CFG_Y_STEP,   {noise[Q_W-2], c.y_step});
    write_register(CFG_JULIA_RE, c.julia_re);
    write_register(CFG_JULIA_IM, c.julia_im);
    write_register(CFG_LIMIT,    {noise[Q_W-1:ITER_W], c.limit});
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Pixel driver: take beats, predict, then send the next one in bursts
  always @(posedge clk_i) begin : pixel_driver
    logic   next_start;
    pixel_t next_pixel;
    if (rst_ni) begin
      next_start = start_i;
      next_pixel = pixel_i;
      if (start_i && !busy_o) begin
        predicted_results.push_back(escape_pixel(pixel_i));
        pixels_taken++;
        next_start = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
          gap_left   = $urandom_range(1, 30);
        end
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_pixels.size() > 0) begin
          next_start = 1'b1;
          next_pixel = pending_pixels.pop_front();
        end
      end
      start_i <= next_start;
      pixel_i <= next_pixel;
    end
  end

  // Result monitor: compare each strobe with the oldest prediction
  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (rst_ni && res_valid_o) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("result beat with no pixel outstanding");
      end else begin
        want = predicted_results.pop_front();
        if (res_o.escaped !== want.escaped)
          report_mismatch($sformatf("escaped got %0d want %0d", res_o.escaped, want.escaped));
        if (res_o.iterations !== want.iterations)
          report_mismatch($sformatf("iterations got %0d want %0d",
                                    res_o.iterations, want.iterations));
        if (res_o.red !== want.red)
          report_mismatch($sformatf("red got %0d want %0d", res_o.red, want.red));
        if (res_o.green !== want.green)
          report_mismatch($sformatf("green got %0d want %0d", res_o.green, want.green));
        if (res_o.blue !== want.blue)
          report_mismatch($sformatf("blue got %0d want %0d", res_o.blue, want.blue));
      end
    end
  end

  // Stimulus: directed settings first, then random settings and pixels
  initial begin : stimulus
    cfg_t setting;
    int   phase;
    int   count;
    int   pick;
    cfg_copy = reset_setting();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset window: corners and one point deep inside the set
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(0, 1023);
    queue_pixel(1023, 0);
    queue_pixel(560, 350);
    drain_pixels();

    // Limit of one: escape decided on the start point alone
    setting = reset_setting();
    setting.limit = 11'd1;
    program_all(setting);
    queue_pixel(0, 0);
    queue_pixel(560, 350);
    drain_pixels();

    // Limit of zero acts as one
    setting.limit = 11'd0;
    program_all(setting);
    queue_pixel(1023, 1023);
    queue_pixel(300, 300);
    drain_pixels();

    // Limit above the maximum, Julia with the reset constant
    setting.limit = 11'd2047;
    setting.mode  = MODE_JULIA;
    program_all(setting);
    queue_pixel(0, 0);
    queue_pixel(512, 350);
    drain_pixels();

    // Mapped point saturates at both ends; z overflows on the first step
    setting.mode   = MODE_MANDELBROT;
    setting.x_min  = 32'h7FFF_FFFF;
    setting.y_min  = 32'h8000_0000;
    setting.x_step = 31'h7FFF_FFFF;
    setting.y_step = 31'h7FFF_FFFF;
    setting.limit  = 11'd5;
    program_all(setting);
    queue_pixel(1023, 0);
    queue_pixel(0, 1023);
    queue_pixel(1023, 1023);
    drain_pixels();

    // Julia with extreme constants from a zero start point
    setting.mode     = MODE_JULIA;
    setting.x_min    = '0;
    setting.y_min    = '0;
    setting.x_step   = '0;
    setting.y_step   = '0;
    setting.julia_re = 32'h8000_0000;
    setting.julia_im = 32'h7FFF_FFFF;
    setting.limit    = 11'd3;
    program_all(setting);
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    drain_pixels();

    // Random phases: mostly plausible windows, some wild ones
    phase = 0;
    while (pixels_queued < RANDOM_PIXELS) begin
      setting.mode = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0) begin
        setting.x_min    = $urandom;
        setting.y_min    = $urandom;
        setting.x_step   = STEP_W'($urandom);
        setting.y_step   = STEP_W'($urandom);
        setting.julia_re = $urandom;
        setting.julia_im = $urandom;
      end else begin
        setting.x_min    = $urandom_range(0, 805306368) - 671088640;
        setting.y_min    = $urandom_range(0, 671088640) - 402653184;
        setting.x_step   = STEP_W'($urandom_range(0, 2000000));
        setting.y_step   = STEP_W'($urandom_range(0, 2000000));
        setting.julia_re = $urandom_range(0, 536870912) - 268435456;
        setting.julia_im = $urandom_range(0, 536870912) - 268435456;
      end
      pick = $urandom_range(0, 19);
      if (pick == 0)      setting.limit = 11'd0;
      else if (pick == 1) setting.limit = 11'd1;
      else if (pick < 15) setting.limit = ITER_W'($urandom_range(2, 40));
      else                setting.limit = ITER_W'($urandom_range(41, 120));
      count = 48;
      // Few pixels under the full limit, since each may run a thousand steps
      if (phase % 6 == 5) begin
        setting.limit = ITER_W'(($urandom_range(0, 1) == 0) ? MAX_ITERATIONS
                                                            : $urandom_range(1025, 2047));
        count = 4;
      end
      program_all(setting);
      repeat (count) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)      queue_pixel(0, $urandom_range(0, 1023));
        else if (pick == 1) queue_pixel(1023, $urandom_range(0, 1023));
        else if (pick == 2) queue_pixel($urandom_range(0, 1023), 1023 * $urandom_range(0, 1));
        else                queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
      end
      drain_pixels();
      phase++;
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### escape_time_fractal_pixel_unit.f
rtl/core/etfp_pkg.sv
rtl/core/etfp_cfg_regs.sv
rtl/core/etfp_mult.sv
rtl/core/etfp_seq.sv
rtl/core/escape_time_fractal_pixel_unit.sv
verif/tb.sv
